### src/wdknn_pkg.sv
package wdknn_pkg;

  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_REC   = 2'd1;
  localparam logic [1:0] MODE_FLUSH = 2'd2;
  localparam logic [1:0] MODE_IGNORED = 2'd3;

  localparam logic [2:0] ST_ACCEPTED = 3'd0;
  localparam logic [2:0] ST_NOT_CHOSEN = 3'd1;
  localparam logic [2:0] ST_CORRUPT = 3'd2;
  localparam logic [2:0] ST_OVER_LIMIT = 3'd3;
  localparam logic [2:0] ST_SELECTION = 3'd4;

  localparam logic [2:0] CFG_STAT_COUNT = 3'd0;
  localparam logic [2:0] CFG_SCEN_COUNT = 3'd1;
  localparam logic [2:0] CFG_SCEN_MASK = 3'd2;
  localparam logic [2:0] CFG_REC_LIMIT = 3'd3;
  localparam logic [2:0] CFG_KEEP_COUNT = 3'd4;

  typedef struct packed {
    logic accept;
    logic diff;
    logic mul_sq;
    logic mul_lo;
    logic mul_hi;
    logic term;
    logic acc;
    logic post;
    logic emit_rec;
    logic emit_sel;
    logic idx_zero;
    logic idx_inc;
    logic idx_dec;
    logic tbl_rd;
    logic fl_rd;
    logic tbl_shift;
    logic tbl_put;
    logic flush_clear;
  } cmd_t;

  typedef struct packed {
    logic elem_skip;
    logic last;
    logic out_free;
    logic status_acc;
    logic idx_is_zero;
    logic idx_at_n;
    logic shift_go;
  } sts_t;

endpackage

### src/wdknn_ram.sv
module wdknn_ram #(
  parameter int W = 8,
  parameter int D = 2,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/wdknn_dp.sv
module wdknn_dp #(
  parameter int MAX_STATS = 256,
  parameter int MAX_KEEP = 64,
  parameter int MAX_SCENARIOS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  wdknn_pkg::cmd_t     cmd,
  output wdknn_pkg::sts_t     sts,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic [1:0]          in_mode,
  input  logic [7:0]          in_stat_index,
  input  logic [7:0]          in_scenario,
  input  logic [31:0]         in_value,
  input  logic [31:0]         in_weight,
  input  logic                in_last,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          out_status,
  output logic [5:0]          out_rank,
  output logic [31:0]         out_record,
  output logic [7:0]          out_scenario,
  output logic [63:0]         out_distance,
  output logic                out_last
);
  import wdknn_pkg::*;

  localparam int SAW = (MAX_STATS > 1) ? $clog2(MAX_STATS) : 1;
  localparam int KAW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
  localparam int TW = 104;

  // configuration
  logic [8:0]  stat_count;
  logic [5:0]  scen_count;
  logic [31:0] scen_mask;
  logic [31:0] rec_limit;
  logic [6:0]  keep_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      stat_count <= 9'd1;
      scen_count <= 6'd1;
      scen_mask <= '0;
      rec_limit <= '0;
      keep_count <= 7'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STAT_COUNT: stat_count <= cfg_data[8:0];
        CFG_SCEN_COUNT: scen_count <= cfg_data[5:0];
        CFG_SCEN_MASK: scen_mask <= cfg_data;
        CFG_REC_LIMIT: rec_limit <= cfg_data;
        CFG_KEEP_COUNT: keep_count <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // record state
  logic [8:0]  pos;
  logic [63:0] partial;
  logic [7:0]  cur_scen;
  logic [31:0] accepted;
  logic [31:0] seen;
  logic [6:0]  fill;
  logic [6:0]  idx;
  logic        last_r;
  logic        elem_on;
  logic signed [31:0] val_r;
  logic [31:0] mag;
  logic [31:0] w_r;
  logic [63:0] sq;
  logic [63:0] plo;
  logic [63:0] phi;
  logic [63:0] term;
  logic [63:0] ins_dist;
  logic [31:0] ins_rec;
  logic [7:0]  ins_scen;

  // reference store: weight high, observed low
  logic          st_we;
  logic [SAW-1:0] st_waddr;
  logic [SAW-1:0] st_raddr;
  logic [63:0]   st_rdata;
  logic [12:0]   idx_ext;
  logic [12:0]   pos_ext;
  logic [31:0]   obs_rd;
  logic [31:0]   wgt_rd;

  assign idx_ext = 13'(in_stat_index);
  assign pos_ext = 13'(pos);
  assign st_waddr = idx_ext[SAW-1:0];
  assign st_raddr = pos_ext[SAW-1:0];
  assign st_we = cmd.accept && (in_mode == MODE_LOAD) && (32'(in_stat_index) < MAX_STATS);
  assign obs_rd = st_rdata[31:0];
  assign wgt_rd = st_rdata[63:32];

  wdknn_ram #(.W(64), .D(MAX_STATS)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata ({in_weight, in_value}),
    .re    (cmd.accept),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  // selection table: distance, record, scenario
  logic [6:0]     ksize;
  logic [6:0]     n_old;
  logic [6:0]     idx_m1;
  logic           tb_we;
  logic [KAW-1:0] tb_waddr;
  logic [KAW-1:0] tb_raddr;
  logic [TW-1:0]  tb_wdata;
  logic [TW-1:0]  tb_rdata;
  logic [63:0]    rd_dist;

  assign ksize = (keep_count == 7'd0) ? 7'd1 :
                 (keep_count > 7'(MAX_KEEP)) ? 7'(MAX_KEEP) : keep_count;
  assign n_old = (fill > ksize) ? ksize : fill;
  assign idx_m1 = idx - 7'd1;
  assign tb_we = (cmd.tbl_shift || cmd.tbl_put) && (idx < ksize);
  assign tb_waddr = idx[KAW-1:0];
  assign tb_raddr = cmd.tbl_rd ? idx_m1[KAW-1:0] : idx[KAW-1:0];
  assign tb_wdata = cmd.tbl_shift ? tb_rdata : {ins_dist, ins_rec, ins_scen};
  assign rd_dist = tb_rdata[TW-1:40];

  wdknn_ram #(.W(TW), .D(MAX_KEEP)) u_table (
    .clk   (clk),
    .we    (tb_we),
    .waddr (tb_waddr),
    .wdata (tb_wdata),
    .re    (cmd.tbl_rd || cmd.fl_rd),
    .raddr (tb_raddr),
    .rdata (tb_rdata)
  );

  // record status
  logic [2:0] rec_status;
  logic [7:0] scen_m1;

  assign scen_m1 = cur_scen - 8'd1;

  always_comb begin
    priority if (cur_scen == 8'd0 || cur_scen > {2'b00, scen_count} ||
                 cur_scen > 8'(MAX_SCENARIOS)) begin
      rec_status = ST_CORRUPT;
    end else if (!scen_mask[scen_m1[4:0]]) begin
      rec_status = ST_NOT_CHOSEN;
    end else if (accepted >= rec_limit) begin
      rec_status = ST_OVER_LIMIT;
    end else begin
      rec_status = ST_ACCEPTED;
    end
  end

  // shared 32x32 multiplier
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;

  always_comb begin
    priority if (cmd.mul_sq) begin
      mul_a = mag;
      mul_b = mag;
    end else if (cmd.mul_lo) begin
      mul_a = sq[31:0];
      mul_b = w_r;
    end else begin
      mul_a = sq[63:32];
      mul_b = w_r;
    end
  end
  assign mul_p = 64'(mul_a) * 64'(mul_b);

  logic signed [32:0] diff;
  logic [32:0] diff_abs;
  logic [64:0] term_sum;
  logic [64:0] acc_sum;

  assign diff = 33'(val_r) - 33'($signed(obs_rd));
  assign diff_abs = diff[32] ? 33'(-diff) : 33'(diff);
  assign term_sum = {1'b0, phi[47:0], 16'h0000} + 65'(plo[63:16]);
  assign acc_sum = {1'b0, partial} + {1'b0, term};

  logic out_free;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.accept && in_mode == MODE_REC) begin
      val_r <= in_value;
      last_r <= in_last;
      elem_on <= (pos < stat_count) && (32'(pos) < MAX_STATS);
    end
    if (cmd.diff) begin
      mag <= diff_abs[31:0];
      w_r <= wgt_rd;
    end
    if (cmd.mul_sq) sq <= mul_p;
    if (cmd.mul_lo) plo <= mul_p;
    if (cmd.mul_hi) phi <= mul_p;
    if (cmd.term) begin
      term <= (|phi[63:48] || term_sum[64]) ? '1 : term_sum[63:0];
    end
    if (cmd.emit_rec) begin
      ins_dist <= partial;
      ins_rec <= seen;
      ins_scen <= cur_scen;
    end
    if (cmd.emit_rec || cmd.emit_sel) begin
      out_status <= cmd.emit_sel ? ST_SELECTION : rec_status;
      out_rank <= cmd.emit_sel ? idx[5:0] : 6'd0;
      out_record <= cmd.emit_sel ? tb_rdata[39:8] : seen;
      out_scenario <= cmd.emit_sel ? tb_rdata[7:0] : cur_scen;
      out_distance <= cmd.emit_sel ? rd_dist : partial;
      out_last <= cmd.emit_sel && (idx + 7'd1 == n_old);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      partial <= '0;
      cur_scen <= '0;
      accepted <= '0;
      seen <= '0;
      fill <= '0;
      idx <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.emit_rec || cmd.emit_sel) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.accept && in_mode == MODE_REC && pos == 9'd0) cur_scen <= in_scenario;
      if (cmd.acc) partial <= acc_sum[64] ? '1 : acc_sum[63:0];
      if (cmd.post && pos != 9'h1ff) pos <= pos + 9'd1;
      if (cmd.emit_rec) begin
        seen <= seen + 32'd1;
        partial <= '0;
        pos <= '0;
        if (rec_status == ST_ACCEPTED) begin
          accepted <= accepted + 32'd1;
          idx <= n_old;
        end
      end
      if (cmd.idx_zero) idx <= '0;
      if (cmd.idx_inc) idx <= idx + 7'd1;
      if (cmd.idx_dec) idx <= idx_m1;
      if (cmd.tbl_put) fill <= (n_old < ksize) ? n_old + 7'd1 : n_old;
      if (cmd.flush_clear) begin
        fill <= '0;
        accepted <= '0;
        seen <= '0;
        partial <= '0;
        pos <= '0;
      end
    end
  end

  assign sts.elem_skip = !elem_on || (wgt_rd == 32'd0);
  assign sts.last = last_r;
  assign sts.out_free = out_free;
  assign sts.status_acc = (rec_status == ST_ACCEPTED);
  assign sts.idx_is_zero = (idx == 7'd0);
  assign sts.idx_at_n = (idx == n_old);
  assign sts.shift_go = rd_dist > ins_dist;

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= 7'(MAX_KEEP)) else $error("table fill above capacity");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_rec || cmd.emit_sel) |-> out_free)
    else $error("result loaded over an untaken one");

  a_shift_idx: assert property (@(posedge clk) disable iff (rst)
    cmd.tbl_shift |-> (idx != 7'd0 && idx <= n_old))
    else $error("table shift outside filled range");

endmodule

### src/wdknn_ctrl.sv
module wdknn_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [1:0]      in_mode,
  output logic            in_ready,
  input  wdknn_pkg::sts_t sts,
  output wdknn_pkg::cmd_t cmd
);
  import wdknn_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DIFF = 4'd1;
  localparam logic [3:0] S_MSQ = 4'd2;
  localparam logic [3:0] S_MLO = 4'd3;
  localparam logic [3:0] S_MHI = 4'd4;
  localparam logic [3:0] S_TERM = 4'd5;
  localparam logic [3:0] S_ACC = 4'd6;
  localparam logic [3:0] S_POST = 4'd7;
  localparam logic [3:0] S_REC = 4'd8;
  localparam logic [3:0] S_ICHK = 4'd9;
  localparam logic [3:0] S_ICMP = 4'd10;
  localparam logic [3:0] S_IPUT = 4'd11;
  localparam logic [3:0] S_FCHK = 4'd12;
  localparam logic [3:0] S_FEMIT = 4'd13;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          unique case (in_mode)
            MODE_REC: state_next = S_DIFF;
            MODE_FLUSH: begin
              cmd.idx_zero = 1'b1;
              state_next = S_FCHK;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_DIFF: begin
        if (sts.elem_skip) begin
          state_next = S_POST;
        end else begin
          cmd.diff = 1'b1;
          state_next = S_MSQ;
        end
      end
      S_MSQ: begin
        cmd.mul_sq = 1'b1;
        state_next = S_MLO;
      end
      S_MLO: begin
        cmd.mul_lo = 1'b1;
        state_next = S_MHI;
      end
      S_MHI: begin
        cmd.mul_hi = 1'b1;
        state_next = S_TERM;
      end
      S_TERM: begin
        cmd.term = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        state_next = S_POST;
      end
      S_POST: begin
        cmd.post = 1'b1;
        state_next = sts.last ? S_REC : S_IDLE;
      end
      S_REC: begin
        if (sts.out_free) begin
          cmd.emit_rec = 1'b1;
          state_next = sts.status_acc ? S_ICHK : S_IDLE;
        end
      end
      // insertion walks down from the fill point, reading a slot in S_ICHK and comparing it in S_ICMP
      S_ICHK: begin
        if (sts.idx_is_zero) begin
          state_next = S_IPUT;
        end else begin
          cmd.tbl_rd = 1'b1;
          state_next = S_ICMP;
        end
      end
      S_ICMP: begin
        if (sts.shift_go) begin
          cmd.tbl_shift = 1'b1;
          cmd.idx_dec = 1'b1;
          state_next = S_ICHK;
        end else begin
          state_next = S_IPUT;
        end
      end
      S_IPUT: begin
        cmd.tbl_put = 1'b1;
        state_next = S_IDLE;
      end
      S_FCHK: begin
        if (sts.idx_at_n) begin
          cmd.flush_clear = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.fl_rd = 1'b1;
          state_next = S_FEMIT;
        end
      end
      S_FEMIT: begin
        if (sts.out_free) begin
          cmd.emit_sel = 1'b1;
          cmd.idx_inc = 1'b1;
          state_next = S_FCHK;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### src/weighted_distance_knn_select.sv
// channel  direction  transaction
// s_*      in         one load entry, one record statistic or a flush request
// m_*      out        one record verdict or one selection entry
// cfg_*    in         one register write, no handshake
//
// a load is taken in S_IDLE; a statistic passes S_DIFF and S_POST when disabled, else
// also S_MSQ, S_MLO, S_MHI, S_TERM and S_ACC (shared 32x32 multiplier used three times,
// then term and accumulate); a record end adds S_REC, then an accepted record takes
// S_ICHK and S_IPUT, plus S_ICMP into a non-empty table and S_ICHK, S_ICMP per slot
// moved; a flush takes S_FCHK, S_FEMIT per entry, then S_FCHK; all counters clear on rst
// a waiting result is held in the output register while the next item is taken
module weighted_distance_knn_select #(
  parameter int MAX_STATS = 256,
  parameter int MAX_KEEP = 64,
  parameter int MAX_SCENARIOS = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [79:0]  s_tdata,  // stat_index, scenario, value, weight
  input  logic [1:0]   s_tuser,  // mode
  input  logic         s_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [111:0] m_tdata,  // rank, record_number, record_scenario, distance, zero pad
  output logic [2:0]   m_tuser,  // status
  output logic         m_tlast,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import wdknn_pkg::*;

  cmd_t cmd;
  sts_t sts;

  logic [5:0]  o_rank;
  logic [31:0] o_record;
  logic [7:0]  o_scen;
  logic [63:0] o_dist;

  assign m_tdata = {2'b00, o_dist, o_scen, o_record, o_rank};

  wdknn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_mode  (s_tuser),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  wdknn_dp #(
    .MAX_STATS     (MAX_STATS),
    .MAX_KEEP      (MAX_KEEP),
    .MAX_SCENARIOS (MAX_SCENARIOS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_mode       (s_tuser),
    .in_stat_index (s_tdata[7:0]),
    .in_scenario   (s_tdata[15:8]),
    .in_value      (s_tdata[47:16]),
    .in_weight     (s_tdata[79:48]),
    .in_last       (s_tlast),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .out_status    (m_tuser),
    .out_rank      (o_rank),
    .out_record    (o_record),
    .out_scenario  (o_scen),
    .out_distance  (o_dist),
    .out_last      (m_tlast)
  );

endmodule
